>>> src/http_chunked_body_decoder_defines.svh
// Assertion macros for the chunked body decoder top level.
`ifndef HTTP_CHUNKED_BODY_DECODER_DEFINES_SVH
`define HTTP_CHUNKED_BODY_DECODER_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define HCBD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hcbd: same-cycle check failed");

// Next-cycle implication, held off during reset.
`define HCBD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hcbd: next-cycle check failed");

`endif

>>> src/hcbd_pkg.sv
// Types and constants of the chunked body decoder.
package hcbd_pkg;

    localparam int LINE_MAX    = 6;
    localparam int SIZE_BITS   = 24;
    localparam int LINE_W      = $clog2(LINE_MAX + 1);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    localparam logic [SIZE_BITS-1:0] SIZE_ZERO = '0;
    localparam logic [SIZE_BITS-1:0] SIZE_ONE  = {{(SIZE_BITS-1){1'b0}}, 1'b1};
    localparam logic [SIZE_BITS-1:0] SIZE_SAT  = '1;
    localparam logic [LINE_W-1:0]    LINE_LIMIT = LINE_W'(LINE_MAX);
    localparam logic [LINE_W-1:0]    LINE_ONE   = {{(LINE_W-1){1'b0}}, 1'b1};
    localparam logic [QCNT_W-1:0]    QCNT_FULL  = QCNT_W'(QUEUE_DEPTH);

    typedef enum logic [2:0] {
        PH_SIZE,
        PH_AFTER_LINE,
        PH_DATA,
        PH_TAIL,
        PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        ST_DATA = 2'd0,
        ST_END  = 2'd1,
        ST_BAD  = 2'd2
    } status_t;

    typedef struct packed {
        phase_t               phase;
        logic [SIZE_BITS-1:0] remaining;
        logic [LINE_W-1:0]    line_chars;
        logic                 digits_closed;
        logic                 held_cr;
    } parse_st_t;

    typedef struct packed {
        logic [7:0] data;
        status_t    status;
    } result_t;

    // One queue entry: the results of one accepted word, first in r0.
    typedef struct packed {
        logic [1:0] cnt;
        result_t    r0;
        result_t    r1;
    } step_t;

endpackage

>>> src/hcbd_front.sv
// Front end: takes body words, runs the chunk framing parser, queues the results.
module hcbd_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                body_valid,
    output logic                body_ready,
    input  logic [7:0]          body_byte,
    input  logic                first_of_body,
    input  logic                q_full,
    output logic                q_push,
    output hcbd_pkg::step_t     q_data
);

    typedef struct packed {
        hcbd_pkg::parse_st_t st;
        hcbd_pkg::step_t     out;
    } ctx_t;

    hcbd_pkg::parse_st_t state_reg;
    hcbd_pkg::parse_st_t state_next;
    ctx_t                step_ctx;
    logic                fire;

    function automatic logic [4:0] hex_value(logic [7:0] b);
        if (b >= 8'h30 && b <= 8'h39) return {1'b1, b[3:0]};
        if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46))
            return {1'b1, b[3:0] + 4'd9};
        return 5'd0;
    endfunction

    function automatic ctx_t put(ctx_t c, logic [7:0] b, hcbd_pkg::status_t s);
        ctx_t r;
        r = c;
        if (r.out.cnt == 2'd0) begin
            r.out.r0.data   = b;
            r.out.r0.status = s;
        end else begin
            r.out.r1.data   = b;
            r.out.r1.status = s;
        end
        r.out.cnt = r.out.cnt + 2'd1;
        return r;
    endfunction

    function automatic ctx_t fail(ctx_t c, hcbd_pkg::status_t s);
        ctx_t r;
        r = put(c, 8'h00, s);
        r.st.phase   = hcbd_pkg::PH_DONE;
        r.st.held_cr = 1'b0;
        return r;
    endfunction

    function automatic ctx_t start_line(ctx_t c);
        ctx_t r;
        r = c;
        r.st.phase         = hcbd_pkg::PH_SIZE;
        r.st.remaining     = hcbd_pkg::SIZE_ZERO;
        r.st.line_chars    = '0;
        r.st.digits_closed = 1'b0;
        r.st.held_cr       = 1'b0;
        return r;
    endfunction

    function automatic ctx_t size_byte(ctx_t c, logic [7:0] b);
        ctx_t       r;
        logic       stop;
        logic [4:0] h;
        r    = c;
        stop = 1'b0;
        h    = hex_value(b);
        if (r.st.held_cr) begin
            r.st.held_cr = 1'b0;
            if (b == hcbd_pkg::CH_LF) begin
                r.st.phase         = hcbd_pkg::PH_AFTER_LINE;
                r.st.line_chars    = '0;
                r.st.digits_closed = 1'b0;
                stop = 1'b1;
            end else if (r.st.line_chars >= hcbd_pkg::LINE_LIMIT) begin
                r    = fail(r, hcbd_pkg::ST_BAD);
                stop = 1'b1;
            end else begin
                // lone CR counts as one line character
                r.st.line_chars = r.st.line_chars + hcbd_pkg::LINE_ONE;
            end
        end
        if (!stop && !r.st.digits_closed) begin
            if (h[4]) begin
                stop = 1'b1;
                if (r.st.line_chars >= hcbd_pkg::LINE_LIMIT) begin
                    r = fail(r, hcbd_pkg::ST_BAD);
                end else begin
                    r.st.line_chars = r.st.line_chars + hcbd_pkg::LINE_ONE;
                    // shift in one nibble, saturate once the top nibble is in use
                    if (r.st.remaining[hcbd_pkg::SIZE_BITS-1 -: 4] != 4'd0)
                        r.st.remaining = hcbd_pkg::SIZE_SAT;
                    else
                        r.st.remaining = {r.st.remaining[hcbd_pkg::SIZE_BITS-5:0], h[3:0]};
                end
            end else begin
                r.st.digits_closed = 1'b1;
                if (r.st.remaining == hcbd_pkg::SIZE_ZERO) begin
                    r    = fail(r, hcbd_pkg::ST_END);
                    stop = 1'b1;
                end
            end
        end
        if (!stop) begin
            if (b == hcbd_pkg::CH_CR)
                r.st.held_cr = 1'b1;
            else if (r.st.line_chars >= hcbd_pkg::LINE_LIMIT)
                r = fail(r, hcbd_pkg::ST_BAD);
            else
                r.st.line_chars = r.st.line_chars + hcbd_pkg::LINE_ONE;
        end
        return r;
    endfunction

    function automatic ctx_t tail_byte(ctx_t c, logic [7:0] b);
        ctx_t r;
        r = c;
        if (r.st.held_cr) begin
            r.st.held_cr = 1'b0;
            if (b == hcbd_pkg::CH_LF)
                r = start_line(r);
            else
                r = fail(r, hcbd_pkg::ST_END);
        end else if (b == hcbd_pkg::CH_CR) begin
            r.st.held_cr = 1'b1;
        end else begin
            // no trailing CR LF: this word already opens the next size line
            r = start_line(r);
            r = size_byte(r, b);
        end
        return r;
    endfunction

    function automatic ctx_t data_byte(ctx_t c, logic [7:0] b);
        ctx_t r;
        r = c;
        if (r.st.remaining == hcbd_pkg::SIZE_ZERO) begin
            r.st.phase = hcbd_pkg::PH_TAIL;
            r = tail_byte(r, b);
        end else begin
            r = put(r, b, hcbd_pkg::ST_DATA);
            r.st.remaining = r.st.remaining - hcbd_pkg::SIZE_ONE;
            if (r.st.remaining == hcbd_pkg::SIZE_ZERO) begin
                r.st.phase   = hcbd_pkg::PH_TAIL;
                r.st.held_cr = 1'b0;
            end
        end
        return r;
    endfunction

    function automatic ctx_t after_line_byte(ctx_t c, logic [7:0] b);
        ctx_t r;
        r = c;
        if (r.st.held_cr) begin
            r.st.held_cr = 1'b0;
            r.st.phase   = hcbd_pkg::PH_DATA;
            if (b != hcbd_pkg::CH_LF) begin
                // the held CR was payload: emit it, then handle this word
                r = data_byte(r, hcbd_pkg::CH_CR);
                if (r.st.phase == hcbd_pkg::PH_DATA)
                    r = data_byte(r, b);
                else
                    r = tail_byte(r, b);
            end
        end else if (b == hcbd_pkg::CH_CR) begin
            r.st.held_cr = 1'b1;
        end else begin
            r.st.phase = hcbd_pkg::PH_DATA;
            r = data_byte(r, b);
        end
        return r;
    endfunction

    assign body_ready = !q_full;
    assign fire       = body_valid && body_ready;

    always_comb
    begin
        step_ctx     = '0;
        step_ctx.st  = state_reg;
        if (first_of_body)
            step_ctx = start_line(step_ctx);
        case (step_ctx.st.phase)
            hcbd_pkg::PH_SIZE:       step_ctx = size_byte(step_ctx, body_byte);
            hcbd_pkg::PH_AFTER_LINE: step_ctx = after_line_byte(step_ctx, body_byte);
            hcbd_pkg::PH_DATA:       step_ctx = data_byte(step_ctx, body_byte);
            hcbd_pkg::PH_TAIL:       step_ctx = tail_byte(step_ctx, body_byte);
            default:                 step_ctx = step_ctx;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        if (fire)
            state_next = step_ctx.st;
    end

    // outputs
    always_comb
    begin
        q_data = step_ctx.out;
        q_push = fire && (step_ctx.out.cnt != 2'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase         <= hcbd_pkg::PH_SIZE;
            state_reg.remaining     <= hcbd_pkg::SIZE_ZERO;
            state_reg.line_chars    <= '0;
            state_reg.digits_closed <= 1'b0;
            state_reg.held_cr       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> src/hcbd_queue.sv
// Short result queue between the parser and the output stage.
module hcbd_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  hcbd_pkg::step_t push_data,
    output logic            full,
    input  logic            pop,
    output hcbd_pkg::step_t pop_data,
    output logic            empty
);

    hcbd_pkg::step_t               entries [hcbd_pkg::QUEUE_DEPTH];
    logic [hcbd_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [hcbd_pkg::QPTR_W-1:0]   wr_ptr_next;
    logic [hcbd_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [hcbd_pkg::QPTR_W-1:0]   rd_ptr_next;
    logic [hcbd_pkg::QCNT_W-1:0]   count_reg;
    logic [hcbd_pkg::QCNT_W-1:0]   count_next;

    assign full     = (count_reg == hcbd_pkg::QCNT_FULL);
    assign empty    = (count_reg == '0);
    assign pop_data = entries[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = wr_ptr_reg + {{(hcbd_pkg::QPTR_W-1){1'b0}}, 1'b1};
        if (pop)
            rd_ptr_next = rd_ptr_reg + {{(hcbd_pkg::QPTR_W-1){1'b0}}, 1'b1};
        case ({push, pop})
            2'b10:   count_next = count_reg + {{(hcbd_pkg::QCNT_W-1){1'b0}}, 1'b1};
            2'b01:   count_next = count_reg - {{(hcbd_pkg::QCNT_W-1){1'b0}}, 1'b1};
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entries[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> src/hcbd_back.sv
// Back end: unpacks queued entries into single result words on the output register.
module hcbd_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_empty,
    input  hcbd_pkg::step_t q_data,
    output logic            q_pop,
    output logic            payload_valid,
    input  logic            payload_ready,
    output logic [7:0]      payload_byte,
    output logic [1:0]      status
);

    logic              out_valid_reg;
    logic              out_valid_next;
    hcbd_pkg::result_t out_reg;
    hcbd_pkg::result_t out_next;
    logic              pend_valid_reg;
    logic              pend_valid_next;
    hcbd_pkg::result_t pend_reg;
    hcbd_pkg::result_t pend_next;
    logic              out_free;

    assign out_free      = !out_valid_reg || payload_ready;
    assign q_pop         = out_free && !pend_valid_reg && !q_empty;
    assign payload_valid = out_valid_reg;
    assign payload_byte  = out_reg.data;
    assign status        = out_reg.status;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        if (out_free)
        begin
            if (pend_valid_reg)
            begin
                // second result of an entry goes out before the next pop
                out_valid_next  = 1'b1;
                out_next        = pend_reg;
                pend_valid_next = 1'b0;
            end
            else if (!q_empty)
            begin
                out_valid_next  = 1'b1;
                out_next        = q_data.r0;
                pend_next       = q_data.r1;
                pend_valid_next = (q_data.cnt == 2'd2);
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        pend_reg <= pend_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

endmodule

>>> src/http_chunked_body_decoder.sv
// Top level of the HTTP chunked body decoder.
//
//   channel   | handshake                     | words
//   ----------+-------------------------------+------------------------------
//   body      | body_valid / body_ready       | body_byte, first_of_body
//   payload   | payload_valid / payload_ready | payload_byte, status
//
// One body word is taken every cycle while the four-entry result queue has room.
// A taken word is queued first and then loaded into the output register.
// A word that makes two results (a held CR that turns out to be data) puts both in one
// entry; the output stage sends them in turn, and the queue absorbs such bursts.
// Reset clears the parser to the start of a size line and empties queue and output.
// A stalled payload port fills the queue, and body_ready drops when it is full.
`include "http_chunked_body_decoder_defines.svh"

module http_chunked_body_decoder (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       body_valid,
    output logic       body_ready,
    input  logic [7:0] body_byte,
    input  logic       first_of_body,
    output logic       payload_valid,
    input  logic       payload_ready,
    output logic [7:0] payload_byte,
    output logic [1:0] status
);

    logic            q_push;
    logic            q_full;
    logic            q_pop;
    logic            q_empty;
    hcbd_pkg::step_t q_wr_data;
    hcbd_pkg::step_t q_rd_data;

    hcbd_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .body_valid    (body_valid),
        .body_ready    (body_ready),
        .body_byte     (body_byte),
        .first_of_body (first_of_body),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_data        (q_wr_data)
    );

    hcbd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wr_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_rd_data),
        .empty     (q_empty)
    );

    hcbd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_data        (q_rd_data),
        .q_pop         (q_pop),
        .payload_valid (payload_valid),
        .payload_ready (payload_ready),
        .payload_byte  (payload_byte),
        .status        (status)
    );

    // a pushed entry holds one or two results
    `HCBD_ASSERT_NOW(a_queue_no_overflow, clk, rst_n, q_push, !q_full)
    `HCBD_ASSERT_NOW(a_queue_no_underflow, clk, rst_n, q_pop, !q_empty)
    `HCBD_ASSERT_NOW(a_entry_count, clk, rst_n, q_push, (q_wr_data.cnt[1] ^ q_wr_data.cnt[0]))
    `HCBD_ASSERT_NEXT(a_push_fills_queue, clk, rst_n, q_push, !q_empty)

endmodule

>>> test/http_chunked_body_decoder_chk.sv
// Checker for the chunked body decoder: predicts payload words and compares them.
module http_chunked_body_decoder_chk (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       body_valid,
    input  logic       body_ready,
    input  logic [7:0] body_byte,
    input  logic       first_of_body,
    input  logic       payload_valid,
    input  logic       payload_ready,
    input  logic [7:0] payload_byte,
    input  logic [1:0] status,
    output int         fails,
    output int         outstanding
);

    hcbd_pkg::phase_t               ph = hcbd_pkg::PH_SIZE;
    logic [hcbd_pkg::SIZE_BITS-1:0] bytes_left = '0;
    int                             line_n = 0;
    bit                             closed = 1'b0;
    bit                             cr_held = 1'b0;
    hcbd_pkg::result_t              due_q[$];
    int                             words_seen = 0;

    function automatic int hex_nibble(logic [7:0] b);
        if (b >= "0" && b <= "9") return int'(b - "0");
        if (b >= "a" && b <= "f") return int'(b - "a") + 10;
        if (b >= "A" && b <= "F") return int'(b - "A") + 10;
        return -1;
    endfunction

    function automatic void emit(logic [7:0] d, hcbd_pkg::status_t s);
        hcbd_pkg::result_t r;
        r.data = d;
        r.status = s;
        due_q.push_back(r);
    endfunction

    function automatic void open_line();
        ph = hcbd_pkg::PH_SIZE;
        bytes_left = '0;
        line_n = 0;
        closed = 1'b0;
        cr_held = 1'b0;
    endfunction

    function automatic void abort(hcbd_pkg::status_t s);
        emit(8'h00, s);
        ph = hcbd_pkg::PH_DONE;
        cr_held = 1'b0;
    endfunction

    function automatic void size_char(logic [7:0] b);
        int                             nib;
        logic [hcbd_pkg::SIZE_BITS+3:0] acc;
        if (cr_held) begin
            cr_held = 1'b0;
            if (b == hcbd_pkg::CH_LF) begin
                ph = hcbd_pkg::PH_AFTER_LINE;
                line_n = 0;
                closed = 1'b0;
                return;
            end
            // a lone CR is just one more line character
            if (line_n >= hcbd_pkg::LINE_MAX) begin
                abort(hcbd_pkg::ST_BAD);
                return;
            end
            line_n++;
        end
        if (!closed) begin
            nib = hex_nibble(b);
            if (nib >= 0) begin
                if (line_n >= hcbd_pkg::LINE_MAX) begin
                    abort(hcbd_pkg::ST_BAD);
                    return;
                end
                line_n++;
                acc = ((hcbd_pkg::SIZE_BITS + 4)'(bytes_left) << 4)
                    + (hcbd_pkg::SIZE_BITS + 4)'(nib);
                bytes_left = (acc > (hcbd_pkg::SIZE_BITS + 4)'(hcbd_pkg::SIZE_SAT))
                           ? hcbd_pkg::SIZE_SAT : acc[hcbd_pkg::SIZE_BITS-1:0];
                return;
            end
            closed = 1'b1;
            if (bytes_left == hcbd_pkg::SIZE_ZERO) begin
                abort(hcbd_pkg::ST_END);
                return;
            end
        end
        if (b == hcbd_pkg::CH_CR) begin
            cr_held = 1'b1;
            return;
        end
        if (line_n >= hcbd_pkg::LINE_MAX) begin
            abort(hcbd_pkg::ST_BAD);
            return;
        end
        line_n++;
    endfunction

    function automatic void tail_char(logic [7:0] b);
        if (cr_held) begin
            cr_held = 1'b0;
            if (b == hcbd_pkg::CH_LF) open_line();
            else abort(hcbd_pkg::ST_END);
            return;
        end
        if (b == hcbd_pkg::CH_CR) begin
            cr_held = 1'b1;
            return;
        end
        // no CR LF after the payload: this byte already opens the next size line
        open_line();
        size_char(b);
    endfunction

    function automatic void data_char(logic [7:0] b);
        if (bytes_left == hcbd_pkg::SIZE_ZERO) begin
            ph = hcbd_pkg::PH_TAIL;
            tail_char(b);
            return;
        end
        emit(b, hcbd_pkg::ST_DATA);
        bytes_left--;
        if (bytes_left == hcbd_pkg::SIZE_ZERO) begin
            ph = hcbd_pkg::PH_TAIL;
            cr_held = 1'b0;
        end
    endfunction

    function automatic void after_line_char(logic [7:0] b);
        if (cr_held) begin
            cr_held = 1'b0;
            ph = hcbd_pkg::PH_DATA;
            if (b == hcbd_pkg::CH_LF) return;
            // the held CR was payload: emit it, then handle this byte
            data_char(hcbd_pkg::CH_CR);
            if (ph == hcbd_pkg::PH_DATA) data_char(b);
            else tail_char(b);
            return;
        end
        if (b == hcbd_pkg::CH_CR) begin
            cr_held = 1'b1;
            return;
        end
        ph = hcbd_pkg::PH_DATA;
        data_char(b);
    endfunction

    function automatic void decode_body_word(logic [7:0] b, logic restart);
        if (restart) open_line();
        case (ph)
            hcbd_pkg::PH_SIZE:       size_char(b);
            hcbd_pkg::PH_AFTER_LINE: after_line_char(b);
            hcbd_pkg::PH_DATA:       data_char(b);
            hcbd_pkg::PH_TAIL:       tail_char(b);
            default:                 ;
        endcase
    endfunction

    always @(posedge clk) begin : watch
        hcbd_pkg::result_t want;
        if (!rst_n) begin
            open_line();
            due_q.delete();
        end else begin
            if (payload_valid && payload_ready) begin
                if (due_q.size() == 0) begin
                    if (fails < 10)
                        $display("payload word %0d unexpected: byte %02h status %0d",
                                 words_seen, payload_byte, status);
                    fails++;
                end else begin
                    want = due_q.pop_front();
                    if (payload_byte !== want.data || status !== want.status) begin
                        if (fails < 10)
                            $display("payload word %0d: expected %02h/%0d, got %02h/%0d",
                                     words_seen, want.data, want.status,
                                     payload_byte, status);
                        fails++;
                    end
                end
                words_seen++;
            end
            if (body_valid && body_ready) decode_body_word(body_byte, first_of_body);
        end
        outstanding = due_q.size();
    end

endmodule

>>> test/http_chunked_body_decoder_tb.sv
// Testbench top for the chunked body decoder: stimulus, flow control and verdict.
module http_chunked_body_decoder_tb;

    logic       clk;
    logic       rst_n;
    logic       body_valid;
    logic       body_ready;
    logic [7:0] body_byte;
    logic       first_of_body;
    logic       payload_valid;
    logic       payload_ready;
    logic [7:0] payload_byte;
    logic [1:0] status;

    int         fails;
    int         outstanding;

    logic [7:0] stim_bytes[$];
    bit         stim_first[$];
    bit         fresh;
    int         words_sent;
    bit         calm;
    bit         hold_off;

    http_chunked_body_decoder i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .body_valid    (body_valid),
        .body_ready    (body_ready),
        .body_byte     (body_byte),
        .first_of_body (first_of_body),
        .payload_valid (payload_valid),
        .payload_ready (payload_ready),
        .payload_byte  (payload_byte),
        .status        (status)
    );

    http_chunked_body_decoder_chk i_chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .body_valid    (body_valid),
        .body_ready    (body_ready),
        .body_byte     (body_byte),
        .first_of_body (first_of_body),
        .payload_valid (payload_valid),
        .payload_ready (payload_ready),
        .payload_byte  (payload_byte),
        .status        (status),
        .fails         (fails),
        .outstanding   (outstanding)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic int idle_draw();
        return calm ? 0 : $urandom_range(0, 5);
    endfunction

    function automatic void put_word(logic [7:0] b);
        stim_bytes.push_back(b);
        stim_first.push_back(fresh);
        fresh = 1'b0;
    endfunction

    function automatic logic [7:0] hex_char(int nib);
        if (nib < 10) return 8'("0" + nib);
        return 8'(($urandom_range(0, 1) ? "a" : "A") + nib - 10);
    endfunction

    function automatic logic [7:0] payload_draw();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0) return hcbd_pkg::CH_CR;
        if (pick == 1) return hcbd_pkg::CH_LF;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic void add_chunk(int size);
        int nd;
        int lead;
        int room;
        int t;
        nd = 1;
        t = size >> 4;
        while (t != 0)
        begin
            nd++;
            t = t >> 4;
        end
        lead = ($urandom_range(0, 3) == 0) ? $urandom_range(0, hcbd_pkg::LINE_MAX - nd) : 0;
        repeat (lead) put_word("0");
        for (int k = nd - 1; k >= 0; k--) put_word(hex_char((size >> (4 * k)) & 15));
        room = hcbd_pkg::LINE_MAX - nd - lead;
        if (room > 0 && $urandom_range(0, 4) == 0)
        begin
            put_word(";");
            repeat ($urandom_range(0, room)) put_word(8'($urandom_range(8'h20, 8'h7e)));
        end
        // lone CR on the line, sometimes pushing it past its limit
        if ($urandom_range(0, 9) == 0)
        begin
            put_word(hcbd_pkg::CH_CR);
            put_word("x");
        end
        put_word(hcbd_pkg::CH_CR);
        put_word(hcbd_pkg::CH_LF);
        if ($urandom_range(0, 6) == 0)
        begin
            put_word(hcbd_pkg::CH_CR);
            put_word(hcbd_pkg::CH_LF);
        end
        repeat (size) put_word(payload_draw());
        if ($urandom_range(0, 6) != 0)
        begin
            put_word(hcbd_pkg::CH_CR);
            put_word(hcbd_pkg::CH_LF);
        end
    endfunction

    function automatic void add_body();
        int kind;
        int ending;
        kind = $urandom_range(0, 99);
        fresh = 1'b1;
        if (kind < 80)
        begin
            repeat ($urandom_range(1, 4))
                add_chunk(($urandom_range(0, 6) == 0) ? $urandom_range(17, 80)
                                                      : $urandom_range(1, 16));
            ending = $urandom_range(0, 19);
            if (ending < 14)
            begin
                repeat ($urandom_range(1, 2)) put_word("0");
                put_word(hcbd_pkg::CH_CR);
                put_word(hcbd_pkg::CH_LF);
                put_word(hcbd_pkg::CH_CR);
                put_word(hcbd_pkg::CH_LF);
            end
            else if (ending < 17)
                put_word(($urandom_range(0, 1) == 0) ? hcbd_pkg::CH_CR : "z");
            // bytes after the end are dropped by the block
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 4)) put_word(8'($urandom_range(0, 255)));
        end
        else if (kind < 90)
        begin
            // size line that may run past its limit, digits or extension
            repeat ($urandom_range(1, 3)) put_word(hex_char($urandom_range(0, 15)));
            if ($urandom_range(0, 1) == 0) put_word(";");
            repeat ($urandom_range(3, 6)) put_word(hex_char($urandom_range(0, 15)));
            put_word(hcbd_pkg::CH_CR);
            put_word(hcbd_pkg::CH_LF);
        end
        else
        begin
            repeat ($urandom_range(1, 12))
            begin
                if ($urandom_range(0, 7) == 0) fresh = 1'b1;
                put_word(8'($urandom_range(0, 255)));
            end
        end
    endfunction

    task automatic drive_word(logic [7:0] b, bit f);
        int gap;
        gap = idle_draw();
        if (gap > 0)
        begin
            body_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        body_valid <= 1'b1;
        body_byte <= b;
        first_of_body <= f;
        do @(posedge clk); while (!body_ready);
        words_sent++;
    endtask

    initial
    begin
        rst_n = 1'b0;
        body_valid = 1'b0;
        body_byte = 8'h00;
        first_of_body = 1'b0;
        words_sent = 0;

        // size line with a lone CR and extension, payload extremes
        fresh = 1'b1;
        put_word("2");
        put_word(hcbd_pkg::CH_CR);
        put_word(";");
        put_word(hcbd_pkg::CH_CR);
        put_word(hcbd_pkg::CH_LF);
        put_word(8'h00);
        put_word(8'hFF);
        put_word(hcbd_pkg::CH_CR);
        put_word(hcbd_pkg::CH_LF);
        // held CR after the size line turns out to be payload, then CR without LF
        put_word("2");
        put_word(hcbd_pkg::CH_CR);
        put_word(hcbd_pkg::CH_LF);
        put_word(hcbd_pkg::CH_CR);
        put_word("Z");
        put_word(hcbd_pkg::CH_CR);
        put_word("q");
        // largest size, then a digit past the line limit
        fresh = 1'b1;
        put_word("F");
        put_word("f");
        put_word("F");
        put_word("f");
        put_word("F");
        put_word("F");
        put_word("7");
        // size line without digits
        fresh = 1'b1;
        put_word("g");

        while (stim_bytes.size() < 1550) add_body();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (stim_bytes[i]) drive_word(stim_bytes[i], stim_first[i]);
        body_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (12) @(posedge clk);
        if (fails == 0 && outstanding == 0)
            $display("http_chunked_body_decoder: match");
        else
            $display("http_chunked_body_decoder: mismatch");
        $finish;
    end

    // payload side: random stall after each word, forced low while held off
    initial
    begin
        int stall;
        stall = 0;
        payload_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (payload_valid && payload_ready) stall = idle_draw();
            else if (stall > 0) stall--;
            payload_ready <= (stall == 0) && !hold_off;
        end
    end

    // alternate between idling and back-to-back stretches
    initial
    begin
        calm = 1'b0;
        forever
        begin
            repeat ($urandom_range(40, 160)) @(posedge clk);
            calm <= !calm;
        end
    end

    // hold the payload side off long enough for the block to fill and stall its input
    initial
    begin
        hold_off = 1'b0;
        wait (words_sent >= 400);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (150) @(posedge clk);
        hold_off <= 1'b0;
        wait (words_sent >= 1100);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (150) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin
        #3000000;
        $display("http_chunked_body_decoder: mismatch");
        $finish;
    end

endmodule
